[src/pes_pkg.sv]
// Shared types and constants for the pixel extreme statistics core.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package pes_pkg;

  localparam int unsigned CH_W        = 8;
  localparam int unsigned SUM_W       = 10;
  localparam int unsigned POS_W       = 12;
  localparam int unsigned PIX_W       = 3 * CH_W;
  localparam int unsigned LOC_W       = 2 * POS_W;
  localparam int unsigned CFG_W       = 13;
  localparam int unsigned NUM_CH      = 3;
  localparam logic [CFG_W-1:0] WIDTH_RESET = 13'd640;

  typedef enum logic [2:0] {
    KIND_BRIGHTEST = 3'd0,
    KIND_DARKEST   = 3'd1,
    KIND_MAX_RED   = 3'd2,
    KIND_MAX_GREEN = 3'd3,
    KIND_MAX_BLUE  = 3'd4,
    KIND_MIN_RED   = 3'd5,
    KIND_MIN_GREEN = 3'd6,
    KIND_MIN_BLUE  = 3'd7
  } report_kind_e;

  // Pixel packs R in the top byte; location packs row above column.
  typedef struct packed {
    logic [PIX_W-1:0]              bright_pix;
    logic [LOC_W-1:0]              bright_pos;
    logic [PIX_W-1:0]              dark_pix;
    logic [LOC_W-1:0]              dark_pos;
    logic [NUM_CH-1:0][CH_W-1:0]   peak_val;
    logic [NUM_CH-1:0][LOC_W-1:0]  peak_pos;
    logic [NUM_CH-1:0][CH_W-1:0]   floor_val;
    logic [NUM_CH-1:0][LOC_W-1:0]  floor_pos;
  } frame_stats_t;

  typedef struct packed {
    logic full;
    logic avail;
  } q_status_t;

endpackage

[src/pes_front.sv]
// Front end: raster counters and per-frame extreme trackers, one pixel a cycle while take_i is high.
// Depends on pes_pkg. Hands a finished frame record to the snapshot queue.
`timescale 1ns / 1ps

module pes_front #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [pes_pkg::CFG_W-1:0]    image_width_i,
  input  logic                         take_i,
  input  logic [pes_pkg::CH_W-1:0]     red_i,
  input  logic [pes_pkg::CH_W-1:0]     green_i,
  input  logic [pes_pkg::CH_W-1:0]     blue_i,
  input  logic                         end_of_frame_i,
  output logic                         snap_push_o,
  output pes_pkg::frame_stats_t        snap_o
);

  localparam int unsigned ColW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RowW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned CmpW  = (ColW + 1 > pes_pkg::CFG_W) ? ColW + 1 : pes_pkg::CFG_W;
  localparam int unsigned PosW  = pes_pkg::POS_W;
  localparam int unsigned SumW  = pes_pkg::SUM_W;
  localparam int unsigned NumCh = pes_pkg::NUM_CH;
  localparam logic [CmpW-1:0] WidthMax = CmpW'(MAX_WIDTH);
  localparam logic [RowW-1:0] RowLast  = RowW'(MAX_HEIGHT - 1);

  logic [ColW-1:0]  col_q, col_d;
  logic [RowW-1:0]  row_q, row_d;
  logic             started_q, started_d;
  logic [SumW-1:0]  bsum_q, bsum_d, dsum_q, dsum_d;
  pes_pkg::frame_stats_t stats_q, stats_d;

  logic [NumCh-1:0][pes_pkg::CH_W-1:0] ch;
  logic [SumW-1:0]          sum;
  logic [pes_pkg::PIX_W-1:0] pix;
  logic [pes_pkg::LOC_W-1:0] pos;
  logic                     first;
  logic [CmpW-1:0]          w_raw, w_eff, col_next;
  logic                     wrap;

  always_comb begin
    ch[0] = red_i;
    ch[1] = green_i;
    ch[2] = blue_i;
    sum   = SumW'(red_i) + SumW'(green_i) + SumW'(blue_i);
    pix   = {red_i, green_i, blue_i};
    pos   = {PosW'(row_q), PosW'(col_q)};
    first = ~started_q;
  end

  // Update trackers; ties keep the earlier pixel.
  always_comb begin
    stats_d = stats_q;
    bsum_d  = bsum_q;
    dsum_d  = dsum_q;
    if (first || sum > bsum_q) begin
      bsum_d             = sum;
      stats_d.bright_pix = pix;
      stats_d.bright_pos = pos;
    end
    if (first || sum < dsum_q) begin
      dsum_d           = sum;
      stats_d.dark_pix = pix;
      stats_d.dark_pos = pos;
    end
    for (int i = 0; i < NumCh; i++) begin
      if (first || ch[i] > stats_q.peak_val[i]) begin
        stats_d.peak_val[i] = ch[i];
        stats_d.peak_pos[i] = pos;
      end
      if (first || ch[i] < stats_q.floor_val[i]) begin
        stats_d.floor_val[i] = ch[i];
        stats_d.floor_pos[i] = pos;
      end
    end
  end

  // Clamp the width and advance the raster counters.
  always_comb begin
    w_raw = CmpW'(image_width_i);
    priority if (w_raw == '0) begin
      w_eff = CmpW'(1);
    end else if (w_raw > WidthMax) begin
      w_eff = WidthMax;
    end else begin
      w_eff = w_raw;
    end
    col_next = CmpW'(col_q) + CmpW'(1);
    wrap     = (col_next >= w_eff);

    col_d     = col_q;
    row_d     = row_q;
    started_d = started_q;
    if (take_i) begin
      if (end_of_frame_i) begin
        col_d     = '0;
        row_d     = '0;
        started_d = 1'b0;
      end else begin
        started_d = 1'b1;
        if (wrap) begin
          col_d = '0;
          if (row_q != RowLast) begin
            row_d = row_q + RowW'(1);
          end
        end else begin
          col_d = ColW'(col_next);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      started_q <= 1'b0;
    end else begin
      col_q     <= col_d;
      row_q     <= row_d;
      started_q <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      stats_q <= stats_d;
      bsum_q  <= bsum_d;
      dsum_q  <= dsum_d;
    end
  end

  assign snap_push_o = take_i & end_of_frame_i;
  assign snap_o      = stats_d;

endmodule

[src/pes_snap_queue.sv]
// Two-entry queue of finished frame records between front and back end.
// Depends on pes_pkg.
`timescale 1ns / 1ps

module pes_snap_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  pes_pkg::frame_stats_t data_i,
  input  logic                  pop_i,
  output pes_pkg::q_status_t    status_o,
  output pes_pkg::frame_stats_t head_o
);

  pes_pkg::frame_stats_t entries_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_q] <= data_i;
    end
  end

  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.avail = (cnt_q != 2'd0);
  assign head_o         = entries_q[rd_q];

endmodule

[src/pes_back.sv]
// Back end: walks a frame record through its eight reports into the result register.
// Depends on pes_pkg.
`timescale 1ns / 1ps

module pes_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pes_pkg::q_status_t          q_status_i,
  input  pes_pkg::frame_stats_t       head_i,
  output logic                        snap_pop_o,
  input  logic                        pop,
  output logic                        empty,
  output logic [2:0]                  report_kind_o,
  output logic [pes_pkg::POS_W-1:0]   pos_x_o,
  output logic [pes_pkg::POS_W-1:0]   pos_y_o,
  output logic [pes_pkg::CH_W-1:0]    pix_red_o,
  output logic [pes_pkg::CH_W-1:0]    pix_green_o,
  output logic [pes_pkg::CH_W-1:0]    pix_blue_o,
  output logic [pes_pkg::CH_W-1:0]    channel_value_o,
  output logic                        last_report_o
);

  localparam int unsigned PosW = pes_pkg::POS_W;
  localparam int unsigned ChW  = pes_pkg::CH_W;

  logic [2:0]               idx_q;
  logic                     valid_q;
  logic                     load;
  pes_pkg::report_kind_e    kind;
  logic [pes_pkg::LOC_W-1:0] sel_pos;
  logic [pes_pkg::PIX_W-1:0] sel_pix;
  logic [ChW-1:0]           sel_val;

  logic [2:0]               kind_q;
  logic [pes_pkg::LOC_W-1:0] pos_q;
  logic [pes_pkg::PIX_W-1:0] pix_q;
  logic [ChW-1:0]           val_q;
  logic                     last_q;

  assign load       = q_status_i.avail && (!valid_q || pop);
  assign snap_pop_o = load && (idx_q == 3'(pes_pkg::KIND_MIN_BLUE));
  assign kind       = pes_pkg::report_kind_e'(idx_q);

  always_comb begin
    sel_pos = '0;
    sel_pix = '0;
    sel_val = '0;
    unique case (kind)
      pes_pkg::KIND_BRIGHTEST: begin
        sel_pos = head_i.bright_pos;
        sel_pix = head_i.bright_pix;
      end
      pes_pkg::KIND_DARKEST: begin
        sel_pos = head_i.dark_pos;
        sel_pix = head_i.dark_pix;
      end
      pes_pkg::KIND_MAX_RED: begin
        sel_pos = head_i.peak_pos[0];
        sel_val = head_i.peak_val[0];
      end
      pes_pkg::KIND_MAX_GREEN: begin
        sel_pos = head_i.peak_pos[1];
        sel_val = head_i.peak_val[1];
      end
      pes_pkg::KIND_MAX_BLUE: begin
        sel_pos = head_i.peak_pos[2];
        sel_val = head_i.peak_val[2];
      end
      pes_pkg::KIND_MIN_RED: begin
        sel_pos = head_i.floor_pos[0];
        sel_val = head_i.floor_val[0];
      end
      pes_pkg::KIND_MIN_GREEN: begin
        sel_pos = head_i.floor_pos[1];
        sel_val = head_i.floor_val[1];
      end
      pes_pkg::KIND_MIN_BLUE: begin
        sel_pos = head_i.floor_pos[2];
        sel_val = head_i.floor_val[2];
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q   <= idx_q + 3'd1;
        valid_q <= 1'b1;
      end else if (pop) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q <= idx_q;
      pos_q  <= sel_pos;
      pix_q  <= sel_pix;
      val_q  <= sel_val;
      last_q <= (kind == pes_pkg::KIND_MIN_BLUE);
    end
  end

  assign empty           = ~valid_q;
  assign report_kind_o   = kind_q;
  assign pos_x_o         = pos_q[PosW-1:0];
  assign pos_y_o         = pos_q[2*PosW-1:PosW];
  assign pix_red_o       = pix_q[3*ChW-1:2*ChW];
  assign pix_green_o     = pix_q[2*ChW-1:ChW];
  assign pix_blue_o      = pix_q[ChW-1:0];
  assign channel_value_o = val_q;
  assign last_report_o   = last_q;

endmodule

[src/pixel_extreme_statistics_core.sv]
// Top level of the pixel extreme statistics core: width register, front end,
// snapshot queue and report back end. Depends on pes_pkg, pes_front,
// pes_snap_queue and pes_back.
`timescale 1ns / 1ps

// Takes one RGB pixel per clock in raster order while full is low and, on
// the pixel marked end_of_frame, queues a record of the frame's brightest
// and darkest pixel (by R+G+B) and the per-channel maxima and minima with
// their positions. The report sequencer drains each record as eight
// results, one per cycle while results are popped; the first one passes
// through the frame record queue and then the result register after the
// end-of-frame pixel is accepted. Full rises only when both entries of the
// two-deep frame record queue are taken, which happens when frames shorter
// than eight pixels arrive back to back or results are not popped. The
// width register is sampled on every pixel and clamped to 1..MAX_WIDTH.

module pixel_extreme_statistics_core #(
  parameter int unsigned MAX_WIDTH  = 4096,
  parameter int unsigned MAX_HEIGHT = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [pes_pkg::CFG_W-1:0]   cfg_data_i,
  input  logic                        push,
  output logic                        full,
  input  logic [pes_pkg::CH_W-1:0]    red_i,
  input  logic [pes_pkg::CH_W-1:0]    green_i,
  input  logic [pes_pkg::CH_W-1:0]    blue_i,
  input  logic                        end_of_frame_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [2:0]                  report_kind_o,
  output logic [pes_pkg::POS_W-1:0]   pos_x_o,
  output logic [pes_pkg::POS_W-1:0]   pos_y_o,
  output logic [pes_pkg::CH_W-1:0]    pix_red_o,
  output logic [pes_pkg::CH_W-1:0]    pix_green_o,
  output logic [pes_pkg::CH_W-1:0]    pix_blue_o,
  output logic [pes_pkg::CH_W-1:0]    channel_value_o,
  output logic                        last_report_o
);

  logic [pes_pkg::CFG_W-1:0] width_q;
  logic                      take;
  logic                      snap_push;
  logic                      snap_pop;
  pes_pkg::frame_stats_t     snap;
  pes_pkg::frame_stats_t     head;
  pes_pkg::q_status_t        q_stat;

  assign cfg_ready_o = 1'b1;
  assign full        = q_stat.full;
  assign take        = push & ~q_stat.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= pes_pkg::WIDTH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      width_q <= cfg_data_i;
    end
  end

  pes_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .image_width_i  (width_q),
    .take_i         (take),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .end_of_frame_i (end_of_frame_i),
    .snap_push_o    (snap_push),
    .snap_o         (snap)
  );

  pes_snap_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (snap_push),
    .data_i   (snap),
    .pop_i    (snap_pop),
    .status_o (q_stat),
    .head_o   (head)
  );

  pes_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_status_i      (q_stat),
    .head_i          (head),
    .snap_pop_o      (snap_pop),
    .pop             (pop),
    .empty           (empty),
    .report_kind_o   (report_kind_o),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o),
    .pix_red_o       (pix_red_o),
    .pix_green_o     (pix_green_o),
    .pix_blue_o      (pix_blue_o),
    .channel_value_o (channel_value_o),
    .last_report_o   (last_report_o)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_push |-> !q_stat.full)
    else $error("frame record pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_pop |-> q_stat.avail)
    else $error("frame record popped from an empty queue");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (last_report_o == (report_kind_o == 3'(pes_pkg::KIND_MIN_BLUE))))
    else $error("last_report does not match the final report kind");

  a_channel_pix_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && report_kind_o != 3'(pes_pkg::KIND_BRIGHTEST)
            && report_kind_o != 3'(pes_pkg::KIND_DARKEST))
      |-> (pix_red_o == '0 && pix_green_o == '0 && pix_blue_o == '0))
    else $error("channel report carries pixel data");

endmodule

[tb/sv/tb_pixel_extreme_statistics_core.sv]
// Self-checking testbench for pixel_extreme_statistics_core: a directed table of pixels and
// width writes, then random frames, all scored against a behavioral model of the trackers.
// Depends on pes_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_pixel_extreme_statistics_core;

  localparam int unsigned MAX_W         = 4096;
  localparam int unsigned MAX_H         = 4096;
  localparam int unsigned NUM_REPORTS   = 8;
  localparam int unsigned RANDOM_PIXELS = 250;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES  = 24;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned N_DIRECTED    = 27;

  localparam pes_pkg::report_kind_e PEAK_KINDS [pes_pkg::NUM_CH] =
    '{pes_pkg::KIND_MAX_RED, pes_pkg::KIND_MAX_GREEN, pes_pkg::KIND_MAX_BLUE};
  localparam pes_pkg::report_kind_e FLOOR_KINDS [pes_pkg::NUM_CH] =
    '{pes_pkg::KIND_MIN_RED, pes_pkg::KIND_MIN_GREEN, pes_pkg::KIND_MIN_BLUE};

  typedef struct packed {
    pes_pkg::report_kind_e     kind;
    logic [pes_pkg::POS_W-1:0] x;
    logic [pes_pkg::POS_W-1:0] y;
    logic [pes_pkg::CH_W-1:0]  r;
    logic [pes_pkg::CH_W-1:0]  g;
    logic [pes_pkg::CH_W-1:0]  b;
    logic [pes_pkg::CH_W-1:0]  chv;
    logic                      last_rep;
  } stat_report_t;

  typedef enum logic [0:0] {
    ROW_PIXEL = 1'b0,
    ROW_WIDTH = 1'b1
  } row_op_e;

  typedef struct packed {
    row_op_e                   op;
    logic [pes_pkg::CH_W-1:0]  r;
    logic [pes_pkg::CH_W-1:0]  g;
    logic [pes_pkg::CH_W-1:0]  b;
    logic                      eof;
    logic [12:0]               reps;
    logic [pes_pkg::CFG_W-1:0] width;
    logic                      known;
    logic [pes_pkg::POS_W-1:0] kx;
    logic [pes_pkg::POS_W-1:0] ky;
  } stim_row_t;

  // known: the eof pixel is the brightest of its frame, at (kx, ky)
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    '{ROW_PIXEL, 255, 255, 255, 1, 1,    0,    1, 0, 0},
    '{ROW_PIXEL, 0,   0,   0,   1, 1,    0,    1, 0, 0},
    '{ROW_PIXEL, 10,  20,  30,  0, 1,    0,    0, 0, 0},
    '{ROW_PIXEL, 200, 5,   7,   0, 1,    0,    0, 0, 0},
    '{ROW_PIXEL, 10,  20,  30,  0, 1,    0,    0, 0, 0},
    '{ROW_PIXEL, 0,   255, 0,   0, 1,    0,    0, 0, 0},
    '{ROW_PIXEL, 200, 5,   7,   0, 1,    0,    0, 0, 0},
    '{ROW_PIXEL, 128, 128, 128, 1, 1,    0,    1, 5, 0},
    '{ROW_WIDTH, 0,   0,   0,   0, 0,    1,    0, 0, 0},
    '{ROW_PIXEL, 1,   2,   3,   0, 1,    0,    0, 0, 0},
    '{ROW_PIXEL, 3,   2,   1,   0, 1,    0,    0, 0, 0},
    '{ROW_PIXEL, 9,   9,   9,   1, 1,    0,    1, 0, 2},
    '{ROW_WIDTH, 0,   0,   0,   0, 0,    0,    0, 0, 0},
    '{ROW_PIXEL, 5,   5,   5,   0, 1,    0,    0, 0, 0},
    '{ROW_PIXEL, 6,   6,   6,   1, 1,    0,    1, 0, 1},
    '{ROW_WIDTH, 0,   0,   0,   0, 0,    8191, 0, 0, 0},
    '{ROW_PIXEL, 50,  50,  50,  0, 40,   0,    0, 0, 0},
    '{ROW_PIXEL, 50,  50,  49,  0, 1,    0,    0, 0, 0},
    '{ROW_PIXEL, 70,  70,  70,  1, 1,    0,    1, 41, 0},
    '{ROW_WIDTH, 0,   0,   0,   0, 0,    4096, 0, 0, 0},
    '{ROW_PIXEL, 100, 100, 100, 0, 5,    0,    0, 0, 0},
    '{ROW_WIDTH, 0,   0,   0,   0, 0,    3,    0, 0, 0},
    '{ROW_PIXEL, 200, 200, 200, 0, 1,    0,    0, 0, 0},
    '{ROW_PIXEL, 201, 201, 201, 1, 1,    0,    1, 0, 1},
    '{ROW_WIDTH, 0,   0,   0,   0, 0,    1,    0, 0, 0},
    '{ROW_PIXEL, 100, 100, 100, 0, 40,   0,    0, 0, 0},
    '{ROW_PIXEL, 255, 0,   128, 1, 1,    0,    1, 0, 40}
  };

  bit clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [pes_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic push = 1'b0;
  logic full;
  logic [pes_pkg::CH_W-1:0] red_i = '0;
  logic [pes_pkg::CH_W-1:0] green_i = '0;
  logic [pes_pkg::CH_W-1:0] blue_i = '0;
  logic end_of_frame_i = 1'b0;
  logic empty;
  logic pop = 1'b0;
  logic [2:0] report_kind_o;
  logic [pes_pkg::POS_W-1:0] pos_x_o;
  logic [pes_pkg::POS_W-1:0] pos_y_o;
  logic [pes_pkg::CH_W-1:0] pix_red_o;
  logic [pes_pkg::CH_W-1:0] pix_green_o;
  logic [pes_pkg::CH_W-1:0] pix_blue_o;
  logic [pes_pkg::CH_W-1:0] channel_value_o;
  logic last_report_o;

  logic bright_known = 1'b0;
  logic [pes_pkg::POS_W-1:0] bright_x = '0;
  logic [pes_pkg::POS_W-1:0] bright_y = '0;

  stat_report_t frame_reports_q [$];
  int unsigned n_err = 0;
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  bit hold_off_req = 1'b0;

  logic [pes_pkg::CFG_W-1:0] width_reg;
  logic [pes_pkg::POS_W-1:0] col_cnt, row_cnt;
  logic started;
  logic [pes_pkg::SUM_W-1:0] bright_sum, dark_sum;
  logic [pes_pkg::PIX_W-1:0] bright_pix, dark_pix;
  logic [pes_pkg::LOC_W-1:0] bright_loc, dark_loc;
  logic [pes_pkg::CH_W-1:0] peak_val [pes_pkg::NUM_CH];
  logic [pes_pkg::CH_W-1:0] floor_val [pes_pkg::NUM_CH];
  logic [pes_pkg::LOC_W-1:0] peak_loc [pes_pkg::NUM_CH];
  logic [pes_pkg::LOC_W-1:0] floor_loc [pes_pkg::NUM_CH];

  pixel_extreme_statistics_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .push            (push),
    .full            (full),
    .red_i           (red_i),
    .green_i         (green_i),
    .blue_i          (blue_i),
    .end_of_frame_i  (end_of_frame_i),
    .empty           (empty),
    .pop             (pop),
    .report_kind_o   (report_kind_o),
    .pos_x_o         (pos_x_o),
    .pos_y_o         (pos_y_o),
    .pix_red_o       (pix_red_o),
    .pix_green_o     (pix_green_o),
    .pix_blue_o      (pix_blue_o),
    .channel_value_o (channel_value_o),
    .last_report_o   (last_report_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic note_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    n_err++;
  endtask

  task automatic check_field(input string name, input logic [pes_pkg::POS_W-1:0] got, want);
    if (got !== want) note_error($sformatf("%s: got %0d expected %0d", name, got, want));
  endtask

  function automatic void clear_frame_trackers();
    col_cnt = '0;
    row_cnt = '0;
    started = 1'b0;
    bright_sum = '0;
    bright_pix = '0;
    bright_loc = '0;
    dark_sum = '0;
    dark_pix = '0;
    dark_loc = '0;
    for (int i = 0; i < pes_pkg::NUM_CH; i++) begin
      peak_val[i] = '0;
      peak_loc[i] = '0;
      floor_val[i] = '0;
      floor_loc[i] = '0;
    end
  endfunction

  function automatic stat_report_t make_report(input pes_pkg::report_kind_e kind,
      input logic [pes_pkg::LOC_W-1:0] loc, input logic [pes_pkg::PIX_W-1:0] pix,
      input logic [pes_pkg::CH_W-1:0] chv);
    return '{kind, loc[pes_pkg::POS_W-1:0], loc[pes_pkg::LOC_W-1:pes_pkg::POS_W],
             pix[23:16], pix[15:8], pix[7:0], chv, kind == pes_pkg::KIND_MIN_BLUE};
  endfunction

  function automatic int track_frame_extremes(input logic [pes_pkg::CH_W-1:0] r, g, b,
      input logic eof, output stat_report_t reps [NUM_REPORTS]);
    logic [pes_pkg::CH_W-1:0] ch [pes_pkg::NUM_CH];
    logic [pes_pkg::SUM_W-1:0] pix_sum;
    logic [pes_pkg::LOC_W-1:0] loc;
    int unsigned w;
    ch[0] = r;
    ch[1] = g;
    ch[2] = b;
    pix_sum = {2'b00, r} + {2'b00, g} + {2'b00, b};
    loc = {row_cnt, col_cnt};
    if (!started || pix_sum > bright_sum) begin
      bright_sum = pix_sum;
      bright_pix = {r, g, b};
      bright_loc = loc;
    end
    if (!started || pix_sum < dark_sum) begin
      dark_sum = pix_sum;
      dark_pix = {r, g, b};
      dark_loc = loc;
    end
    for (int i = 0; i < pes_pkg::NUM_CH; i++) begin
      if (!started || ch[i] > peak_val[i]) begin
        peak_val[i] = ch[i];
        peak_loc[i] = loc;
      end
      if (!started || ch[i] < floor_val[i]) begin
        floor_val[i] = ch[i];
        floor_loc[i] = loc;
      end
    end
    started = 1'b1;
    w = 32'(width_reg);
    if (w < 1) w = 1;
    if (w > MAX_W) w = MAX_W;
    if (32'(col_cnt) + 1 >= w) begin
      col_cnt = '0;
      row_cnt = (32'(row_cnt) + 1 < MAX_H) ? row_cnt + 1'b1 : pes_pkg::POS_W'(MAX_H - 1);
    end else begin
      col_cnt = col_cnt + 1'b1;
    end
    if (!eof) return 0;
    reps[0] = make_report(pes_pkg::KIND_BRIGHTEST, bright_loc, bright_pix, '0);
    reps[1] = make_report(pes_pkg::KIND_DARKEST, dark_loc, dark_pix, '0);
    for (int i = 0; i < pes_pkg::NUM_CH; i++) begin
      reps[2 + i] = make_report(PEAK_KINDS[i], peak_loc[i], '0, peak_val[i]);
      reps[5 + i] = make_report(FLOOR_KINDS[i], floor_loc[i], '0, floor_val[i]);
    end
    clear_frame_trackers();
    return NUM_REPORTS;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    stat_report_t want;
    stat_report_t fresh [NUM_REPORTS];
    int n;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (frame_reports_q.size() == 0) begin
          note_error($sformatf("report kind %0d with none pending", report_kind_o));
        end else begin
          want = frame_reports_q.pop_front();
          check_field("report_kind", report_kind_o, want.kind);
          check_field("pos_x", pos_x_o, want.x);
          check_field("pos_y", pos_y_o, want.y);
          check_field("pix_red", pix_red_o, want.r);
          check_field("pix_green", pix_green_o, want.g);
          check_field("pix_blue", pix_blue_o, want.b);
          check_field("channel_value", channel_value_o, want.chv);
          check_field("last_report", last_report_o, want.last_rep);
        end
      end
      if (push && !full) begin
        n = track_frame_extremes(red_i, green_i, blue_i, end_of_frame_i, fresh);
        if (n != 0 && bright_known)
          fresh[0] = '{pes_pkg::KIND_BRIGHTEST, bright_x, bright_y, red_i, green_i, blue_i,
                       '0, 1'b0};
        for (int k = 0; k < n; k++) frame_reports_q.push_back(fresh[k]);
      end
      if (cfg_valid_i && cfg_ready_o) width_reg = cfg_data_i;
    end
  end

  task automatic offer_pixel(input logic [pes_pkg::CH_W-1:0] r, g, b, input logic eof,
      input logic known, input logic [pes_pkg::POS_W-1:0] kx, ky);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    push <= 1'b1;
    red_i <= r;
    green_i <= g;
    blue_i <= b;
    end_of_frame_i <= eof;
    bright_known <= known;
    bright_x <= kx;
    bright_y <= ky;
    do @(posedge clk_i); while (full);
  endtask

  task automatic write_width(input logic [pes_pkg::CFG_W-1:0] w);
    push <= 1'b0;
    do @(posedge clk_i); while (frame_reports_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    burst_left = 0;
  endtask

  function automatic logic [pes_pkg::CFG_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 1;
      2: return 2;
      3: return 3;
      4: return MAX_W;
      5: return 8191;
      6: return $urandom_range(1, 16);
      7: return $urandom_range(4, 9);
      8: return $urandom_range(0, 8191);
      default: return pes_pkg::WIDTH_RESET;
    endcase
  endfunction

  function automatic logic [pes_pkg::CH_W-1:0] pick_channel(input int unsigned style);
    case (style)
      0: return $urandom_range(0, 255);
      1: return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 3) : $urandom_range(252, 255);
      default: return ($urandom_range(0, 1) == 0) ? 8'd0 : 8'd255;
    endcase
  endfunction

  initial begin : receiver
    int unsigned seg, mode;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      mode = $urandom_range(0, 3);
      seg = $urandom_range(8, 40);
      for (int k = 0; k < seg; k++) begin
        case (mode)
          0: pop <= 1'b1;
          1: pop <= $urandom_range(0, 1);
          2: pop <= ($urandom_range(0, 3) == 0);
          default: pop <= (k % 7) < 3;
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int unsigned sent, flen, style;
    stim_row_t row;
    width_reg = pes_pkg::WIDTH_RESET;
    clear_frame_trackers();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      if (row.op == ROW_WIDTH) begin
        write_width(row.width);
      end else begin
        repeat (row.reps) offer_pixel(row.r, row.g, row.b, row.eof, row.known, row.kx, row.ky);
      end
    end

    // hold the receiver off while single-pixel frames pile up
    write_width(pick_width());
    hold_off_req = 1'b1;
    sent = 0;
    repeat (24) begin
      offer_pixel(pick_channel(0), pick_channel(0), pick_channel(0), 1'b1, 1'b0, '0, '0);
      sent++;
    end

    while (sent < RANDOM_PIXELS) begin
      if ($urandom_range(0, 4) == 0) write_width(pick_width());
      flen = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      style = $urandom_range(0, 2);
      for (int p = 1; p <= flen; p++) begin
        offer_pixel(pick_channel(style), pick_channel(style), pick_channel(style),
                    p == flen, 1'b0, '0, '0);
        sent++;
      end
    end

    push <= 1'b0;
    do @(posedge clk_i); while (frame_reports_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_err == 0 && frame_reports_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
